// ----- sv/snnc_pkg.sv -----
// Shared types and constants for the scaled nearest-neighbor classifier.
// Used by snnc_ctrl, snnc_datapath and the top level; depends on nothing.
package snnc_pkg;

	// Field widths of the transaction payload and the configuration port
	localparam int OP_W     = 2;
	localparam int FILL_W   = 15;
	localparam int RATIO_W  = 16;
	localparam int LABEL_W  = 8;
	localparam int SCALE_W  = 16;
	localparam int CFG_IDX_W = 1;

	// Default table depth
	localparam int TABLE_ENTRIES_DEF = 64;

	// Op codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILL_SCALE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_SCALE = 1'b1;

	// Reset value of both inverse scales (1.0 in Q8.8)
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	// Kind of result to present for the current transaction
	typedef enum logic [1:0] {
		RES_NONE,
		RES_QUERY,
		RES_REFUSED
	} res_kind_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      capture;      // latch query features, restart scan
		logic      clear_table;  // entry count back to zero
		logic      write_entry;  // store input item at entry count
		logic      issue;        // read one entry and push it into the pipe
		logic      load_out;     // load the output register
		res_kind_t res_kind;     // what load_out presents
	} snnc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic table_full;
		logic table_empty;
		logic scan_last;   // current scan index is the last stored entry
		logic pipe_busy;   // some entry still in the distance pipe
	} snnc_status_t;

endpackage

// ----- sv/snnc_datapath.sv -----
// Datapath: reference table memory, distance pipeline, best-match tracking,
// configuration registers and output payload register. Depends on snnc_pkg.
module snnc_datapath #(
	parameter int TABLE_ENTRIES = snnc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [snnc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [snnc_pkg::SCALE_W-1:0]      cfg_data,
	input  logic [snnc_pkg::FILL_W-1:0]       fill_feature,
	input  logic [snnc_pkg::RATIO_W-1:0]      ratio_feature,
	input  logic [snnc_pkg::LABEL_W-1:0]      class_label,
	input  snnc_pkg::snnc_cmd_t               cmd,
	output snnc_pkg::snnc_status_t            status,
	output logic [snnc_pkg::LABEL_W-1:0]      match_label,
	output logic                              match_found,
	output logic                              load_refused
);
	import snnc_pkg::*;

	localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int WORD_W = FILL_W + RATIO_W + LABEL_W;
	localparam int FPROD_W = FILL_W + SCALE_W;
	localparam int RPROD_W = RATIO_W + SCALE_W;
	localparam int FSQ_W  = 2 * FPROD_W;
	localparam int RSQ_W  = 2 * RPROD_W;
	localparam int DIST_W = ((FSQ_W > RSQ_W) ? FSQ_W : RSQ_W) + 1;

	// Configuration and control registers
	logic [SCALE_W-1:0] fill_scale_q, ratio_scale_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic               have_q;

	// Query features
	logic [FILL_W-1:0]  q_fill_q;
	logic [RATIO_W-1:0] q_ratio_q;

	// Table memory and pipeline payload
	logic [WORD_W-1:0]  mem [TABLE_ENTRIES];
	logic [WORD_W-1:0]  rd_word_s1;
	logic [FILL_W-1:0]  fill_mag_s2;
	logic [RATIO_W-1:0] ratio_mag_s2;
	logic [LABEL_W-1:0] label_s2, label_s3, label_s4;
	logic [FPROD_W-1:0] fill_prod_s3;
	logic [RPROD_W-1:0] ratio_prod_s3;
	logic [FSQ_W-1:0]   fill_sq_s4;
	logic [RSQ_W-1:0]   ratio_sq_s4;
	logic [DIST_W-1:0]  best_q;
	logic [LABEL_W-1:0] best_label_q;
	logic [LABEL_W-1:0] match_label_q;
	logic               match_found_q, load_refused_q;

	// Unpacked read word and combinational helpers
	logic [FILL_W-1:0]  rd_fill;
	logic [RATIO_W-1:0] rd_ratio;
	logic [LABEL_W-1:0] rd_label;
	logic [DIST_W-1:0]  dist_sum;
	logic               take_new;

	assign rd_fill  = rd_word_s1[WORD_W-1 -: FILL_W];
	assign rd_ratio = rd_word_s1[LABEL_W +: RATIO_W];
	assign rd_label = rd_word_s1[LABEL_W-1:0];

	assign dist_sum = DIST_W'(fill_sq_s4) + DIST_W'(ratio_sq_s4);
	// strict less keeps the earliest entry on ties
	assign take_new = v_s4 && (!have_q || (dist_sum < best_q));

	// Status to controller
	assign status.table_full  = (count_q == CNT_W'(TABLE_ENTRIES));
	assign status.table_empty = (count_q == '0);
	assign status.scan_last   = ((scan_idx_q + CNT_W'(1)) == count_q);
	assign status.pipe_busy   = v_s1 | v_s2 | v_s3 | v_s4;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_scale_q  <= SCALE_RESET;
			ratio_scale_q <= SCALE_RESET;
			count_q       <= '0;
			scan_idx_q    <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			have_q        <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FILL_SCALE:  fill_scale_q  <= cfg_data;
					REG_RATIO_SCALE: ratio_scale_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear_table) begin
				count_q <= '0;
			end else if (cmd.write_entry) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.capture) begin
				scan_idx_q <= '0;
			end else if (cmd.issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.capture) begin
				have_q <= 1'b0;
			end else if (take_new) begin
				have_q <= 1'b1;
			end
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			mem[count_q[ADDR_W-1:0]] <= {fill_feature, ratio_feature, class_label};
		end
		rd_word_s1 <= mem[scan_idx_q[ADDR_W-1:0]];
	end

	// Distance pipeline: difference, scale, square, then sum and compare
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			q_fill_q  <= fill_feature;
			q_ratio_q <= ratio_feature;
		end
		fill_mag_s2  <= (q_fill_q >= rd_fill) ? (q_fill_q - rd_fill) : (rd_fill - q_fill_q);
		ratio_mag_s2 <= (q_ratio_q >= rd_ratio) ? (q_ratio_q - rd_ratio)
		                                        : (rd_ratio - q_ratio_q);
		label_s2     <= rd_label;
		fill_prod_s3  <= FPROD_W'(fill_mag_s2) * FPROD_W'(fill_scale_q);
		ratio_prod_s3 <= RPROD_W'(ratio_mag_s2) * RPROD_W'(ratio_scale_q);
		label_s3      <= label_s2;
		fill_sq_s4    <= FSQ_W'(fill_prod_s3) * FSQ_W'(fill_prod_s3);
		ratio_sq_s4   <= RSQ_W'(ratio_prod_s3) * RSQ_W'(ratio_prod_s3);
		label_s4      <= label_s3;
		if (take_new) begin
			best_q       <= dist_sum;
			best_label_q <= label_s4;
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			match_found_q  <= (cmd.res_kind == RES_QUERY) && have_q;
			match_label_q  <= ((cmd.res_kind == RES_QUERY) && have_q) ? best_label_q : '0;
			load_refused_q <= (cmd.res_kind == RES_REFUSED);
		end
	end

	assign match_label  = match_label_q;
	assign match_found  = match_found_q;
	assign load_refused = load_refused_q;

endmodule

// ----- sv/snnc_ctrl.sv -----
// Controller: transaction handshake, scan sequencing and output valid.
// Drives snnc_datapath through snnc_cmd_t; depends on snnc_pkg.
module snnc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [snnc_pkg::OP_W-1:0]     op,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  snnc_pkg::snnc_status_t        status,
	output snnc_pkg::snnc_cmd_t           cmd
);
	import snnc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;
	logic      out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd = '0;
		cmd.res_kind = kind_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (op)
						OP_CLEAR: cmd.clear_table = 1'b1;
						OP_LOAD:  cmd.write_entry = !status.table_full;
						default: ;
					endcase
				end
			end
			S_SCAN:  cmd.issue = 1'b1;
			S_DONE:  cmd.load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// State, result kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= RES_NONE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (op)
							OP_LOAD: begin
								state_q <= S_DONE;
								kind_q  <= status.table_full ? RES_REFUSED : RES_NONE;
							end
							OP_QUERY: begin
								kind_q  <= RES_QUERY;
								state_q <= status.table_empty ? S_DONE : S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
								kind_q  <= RES_NONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (status.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/scaled_nearest_neighbor_classifier_core.sv -----
// Scaled nearest-neighbor classifier: top level joining controller and datapath.
// Depends on snnc_pkg, snnc_ctrl and snnc_datapath.
//
// Usage: each input transaction (in_valid/in_ready) carries an op: clear the
// table, load one labelled entry, or query the nearest stored entry. Every
// transaction yields exactly one output transaction (out_valid/out_ready).
// Configuration: cfg_write with cfg_index 0 (fill inverse scale) or 1 (ratio
// inverse scale), data on cfg_data; write only while the block is idle.
// Sequencing: clear, load, unused op and query of an empty table go from
// acceptance to the done state, which loads the output register once it is free.
// A query scans all N entries before its result goes out; the table memory
// has one read port, so the scan reads one entry per cycle, followed by a
// five-stage distance pipeline (read, difference, scale multiply, square,
// sum and compare), which drains before the output register is loaded.
// One transaction is processed at a time; in_ready returns once its result is
// in the output register, so the next transaction is accepted while that
// result still waits. A receiver stall holds the result and, once the next
// transaction finishes, holds the block until the output register frees.
// Reset clears the entry count and sets both inverse scales to 1.0; table
// contents are not cleared and no clearing pass is needed.
module scaled_nearest_neighbor_classifier_core #(
	parameter int TABLE_ENTRIES = snnc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [snnc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [snnc_pkg::SCALE_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [snnc_pkg::OP_W-1:0]         op,
	input  logic [snnc_pkg::FILL_W-1:0]       fill_feature,
	input  logic [snnc_pkg::RATIO_W-1:0]      ratio_feature,
	input  logic [snnc_pkg::LABEL_W-1:0]      class_label,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [snnc_pkg::LABEL_W-1:0]      match_label,
	output logic                              match_found,
	output logic                              load_refused
);
	import snnc_pkg::*;

	snnc_cmd_t    cmd;
	snnc_status_t status;

	snnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	snnc_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fill_feature  (fill_feature),
		.ratio_feature (ratio_feature),
		.class_label   (class_label),
		.cmd           (cmd),
		.status        (status),
		.match_label   (match_label),
		.match_found   (match_found),
		.load_refused  (load_refused)
	);

endmodule

// ----- bench/tb_scaled_nearest_neighbor_classifier_core.sv -----
// Self-checking testbench for scaled_nearest_neighbor_classifier_core.
// Holds a scoreboard that predicts each classifier result; drives random ops and idles.
// Depends on snnc_pkg and the classifier RTL only.
module tb_scaled_nearest_neighbor_classifier_core;
	timeunit 1ns;
	timeprecision 1ps;

	import snnc_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
	localparam int MAX_IDLE = 10;
	localparam int IDLE_GAP = 8;
	localparam int FINAL_WAIT = 2 * TABLE_DEPTH + 16;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 160;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Expected output fields of one transaction
	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               found;
		logic               refused;
	} match_t;

	// Shadow copy of the reference table plus queue of expected matches
	class match_board;
		logic [15:0]        entry_fill [TABLE_DEPTH];
		logic [15:0]        entry_ratio [TABLE_DEPTH];
		logic [LABEL_W-1:0] entry_label [TABLE_DEPTH];
		int unsigned        entry_count;
		logic [SCALE_W-1:0] fill_scale;
		logic [SCALE_W-1:0] ratio_scale;
		match_t             pending_matches [$];
		int unsigned        fail_count;

		function new();
			entry_count = 0;
			fill_scale = SCALE_RESET;
			ratio_scale = SCALE_RESET;
			fail_count = 0;
		endfunction

		// (|a - b| * scale)^2, exact in 64 bits
		function logic [63:0] scaled_square(logic [15:0] a, logic [15:0] b,
				logic [SCALE_W-1:0] scale);
			logic [15:0] mag;
			logic [31:0] prod;
			logic [63:0] sq;
			mag = (a >= b) ? a - b : b - a;
			prod = mag * scale;
			sq = prod * prod;
			return sq;
		endfunction

		// Apply one accepted transaction and queue the match it must produce
		function void note_accepted(logic [OP_W-1:0] op_c, logic [FILL_W-1:0] fill_c,
				logic [RATIO_W-1:0] ratio_c, logic [LABEL_W-1:0] label_c);
			match_t res;
			logic [64:0] d;
			logic [64:0] best;
			res = '0;
			best = '0;
			case (op_c)
				OP_CLEAR: entry_count = 0;
				OP_LOAD: begin
					if (entry_count >= TABLE_DEPTH) begin
						res.refused = 1'b1;
					end else begin
						entry_fill[entry_count] = {1'b0, fill_c};
						entry_ratio[entry_count] = ratio_c;
						entry_label[entry_count] = label_c;
						entry_count++;
					end
				end
				OP_QUERY: begin
					// 65-bit sum keeps the carry; ties keep the earliest entry
					for (int unsigned i = 0; i < entry_count; i++) begin
						d = {1'b0, scaled_square({1'b0, fill_c}, entry_fill[i], fill_scale)}
							+ {1'b0, scaled_square(ratio_c, entry_ratio[i], ratio_scale)};
						if (!res.found || d < best) begin
							res.found = 1'b1;
							best = d;
							res.label = entry_label[i];
						end
					end
				end
				default: ; // unused op: no state change, all fields zero
			endcase
			pending_matches.insert(pending_matches.size(), res);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				fail_count++;
			end
		endfunction

		// Compare one output transaction with the oldest expectation
		function void check_match(logic [LABEL_W-1:0] label_o, logic found_o,
				logic refused_o);
			match_t want;
			if (pending_matches.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual label %0d found %0b refused %0b",
					$time, label_o, found_o, refused_o);
				fail_count++;
				return;
			end
			want = pending_matches.pop_front();
			if (^{label_o, found_o, refused_o} === 1'bx) begin
				$display("%0t: unknown output, expected label %0d found %0b refused %0b, actual %b %b %b",
					$time, want.label, want.found, want.refused, label_o, found_o, refused_o);
				fail_count++;
				return;
			end
			compare_field("match_label", want.label, label_o);
			compare_field("match_found", want.found, found_o);
			compare_field("load_refused", want.refused, refused_o);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCALE_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     op;
	logic [FILL_W-1:0]   fill_feature;
	logic [RATIO_W-1:0]  ratio_feature;
	logic [LABEL_W-1:0]  class_label;
	logic                out_valid;
	logic                out_ready;
	logic [LABEL_W-1:0]  match_label;
	logic                match_found;
	logic                load_refused;

	match_board  board;
	int unsigned work_items = 0;
	int unsigned idle_max = MAX_IDLE;
	int unsigned quiet_cycles;

	scaled_nearest_neighbor_classifier_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.fill_feature (fill_feature),
		.ratio_feature(ratio_feature),
		.class_label  (class_label),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.match_label  (match_label),
		.match_found  (match_found),
		.load_refused (load_refused)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_match(match_label, match_found, load_refused);
	end

	// Watchdog: too long without any transaction on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver: random stall before taking each result
	initial begin
		int unsigned stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, idle_max);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// One input transaction after a random gap; valid stays up across back-to-back items
	task automatic send_item(logic [OP_W-1:0] op_c, logic [FILL_W-1:0] fill_c,
			logic [RATIO_W-1:0] ratio_c, logic [LABEL_W-1:0] label_c);
		int unsigned gap;
		gap = $urandom_range(0, idle_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_c;
		fill_feature <= fill_c;
		ratio_feature <= ratio_c;
		class_label <= label_c;
		do @(posedge clk); while (!in_ready);
		board.note_accepted(op_c, fill_c, ratio_c, label_c);
		work_items++;
	endtask

	// Hold off input until every expected match has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_matches.size() != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	// Write both inverse scales; only called while idle
	task automatic write_scales(logic [SCALE_W-1:0] fill_s, logic [SCALE_W-1:0] ratio_s);
		cfg_write <= 1'b1;
		cfg_index <= REG_FILL_SCALE;
		cfg_data <= fill_s;
		@(posedge clk);
		cfg_index <= REG_RATIO_SCALE;
		cfg_data <= ratio_s;
		@(posedge clk);
		cfg_write <= 1'b0;
		board.fill_scale = fill_s;
		board.ratio_scale = ratio_s;
	endtask

	function automatic logic [FILL_W-1:0] draw_fill();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 15'd25600;
			3, 4, 5, 6: return FILL_W'($urandom_range(0, 25600));
			default: return FILL_W'($urandom);
		endcase
	endfunction

	function automatic logic [RATIO_W-1:0] draw_ratio();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 16'd256;
			3, 4, 5: return RATIO_W'($urandom_range(0, 1024));
			default: return RATIO_W'($urandom);
		endcase
	endfunction

	function automatic logic [FILL_W-1:0] nudge_fill(logic [FILL_W-1:0] base);
		int v;
		v = int'(base) + int'($urandom_range(0, 64)) - 32;
		if (v < 0)
			v = 0;
		else if (v > 32767)
			v = 32767;
		return FILL_W'(v);
	endfunction

	function automatic logic [RATIO_W-1:0] nudge_ratio(logic [RATIO_W-1:0] base);
		int v;
		v = int'(base) + int'($urandom_range(0, 64)) - 32;
		if (v < 0)
			v = 0;
		else if (v > 65535)
			v = 65535;
		return RATIO_W'(v);
	endfunction

	// Clear (most of the time), load a batch with occasional unused ops, then query near stored entries or at random
	task automatic run_sequence();
		int unsigned n_load;
		int unsigned n_query;
		int unsigned pick;
		int unsigned idx;
		logic [FILL_W-1:0] f;
		logic [RATIO_W-1:0] r;
		idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
		if ($urandom_range(0, 3) != 0)
			send_item(OP_CLEAR, draw_fill(), draw_ratio(), LABEL_W'($urandom));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			n_load = TABLE_DEPTH - board.entry_count + $urandom_range(1, 3);
		else if (pick <= 2)
			n_load = $urandom_range(9, 40);
		else
			n_load = $urandom_range(0, 8);
		repeat (n_load) begin
			if ($urandom_range(0, 19) == 0)
				send_item(OP_UNUSED, draw_fill(), draw_ratio(), LABEL_W'($urandom));
			// some loads repeat a stored vector to force distance ties
			if (board.entry_count != 0 && $urandom_range(0, 4) == 0) begin
				idx = $urandom_range(0, board.entry_count - 1);
				f = board.entry_fill[idx][FILL_W-1:0];
				r = board.entry_ratio[idx];
			end else begin
				f = draw_fill();
				r = draw_ratio();
			end
			send_item(OP_LOAD, f, r, LABEL_W'($urandom));
		end
		n_query = $urandom_range(1, 6);
		repeat (n_query) begin
			pick = $urandom_range(0, 5);
			if (board.entry_count != 0 && pick <= 2) begin
				idx = $urandom_range(0, board.entry_count - 1);
				f = board.entry_fill[idx][FILL_W-1:0];
				r = board.entry_ratio[idx];
				if (pick != 0) begin
					f = nudge_fill(f);
					r = nudge_ratio(r);
				end
			end else begin
				f = draw_fill();
				r = draw_ratio();
			end
			send_item(OP_QUERY, f, r, LABEL_W'($urandom));
		end
	endtask

	// Directed corners: empty table, unused op, ties, clear, zero scale, distance carry
	task automatic run_directed();
		send_item(OP_QUERY, '0, '0, '0);
		send_item(OP_UNUSED, '1, '1, '1);
		send_item(OP_LOAD, '0, '0, 8'hAA);
		send_item(OP_LOAD, '1, '1, 8'h55);
		send_item(OP_LOAD, '0, '0, 8'h11);
		send_item(OP_QUERY, '0, '0, '0);
		send_item(OP_QUERY, '1, '1, '1);
		send_item(OP_QUERY, 15'd16000, 16'd30000, '0);
		send_item(OP_LOAD, 15'd25600, 16'd256, 8'hFF);
		send_item(OP_QUERY, 15'd25600, 16'd300, '0);
		send_item(OP_CLEAR, '1, '1, '1);
		send_item(OP_QUERY, 15'd100, 16'd100, '0);
		send_item(OP_LOAD, 15'd5, 16'd5, 8'h01);
		send_item(OP_QUERY, 15'd5, 16'd5, '0);
		settle();
		// fill difference carries no weight
		write_scales('0, SCALE_RESET);
		send_item(OP_LOAD, '0, 16'd1000, 8'h22);
		send_item(OP_QUERY, '1, 16'd1000, '0);
		settle();
		// far entry overflows 64 bits and must lose to the near one
		write_scales('1, '1);
		send_item(OP_CLEAR, '0, '0, '0);
		send_item(OP_LOAD, '0, '0, 8'h33);
		send_item(OP_LOAD, '1, 16'd1, 8'h44);
		send_item(OP_QUERY, '1, '1, '0);
		send_item(OP_QUERY, '0, '0, '0);
		settle();
	endtask

	// Main sequence
	initial begin
		int unsigned phase_target;
		board = new();
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_FILL_SCALE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		op <= OP_CLEAR;
		fill_feature <= '0;
		ratio_feature <= '0;
		class_label <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: write_scales(SCALE_RESET, SCALE_RESET);
				1: write_scales('1, '1);
				2: write_scales('0, '0);
				3: write_scales('0, SCALE_W'($urandom));
				4: write_scales(SCALE_W'($urandom), '0);
				5: write_scales(16'd1, SCALE_W'($urandom_range(1, 1024)));
				default: write_scales(SCALE_W'($urandom), SCALE_W'($urandom));
			endcase
			phase_target = work_items + ITEMS_PER_PHASE;
			while (work_items < phase_target)
				run_sequence();
			settle();
		end
		repeat (FINAL_WAIT) @(posedge clk);
		if (board.fail_count == 0 && board.pending_matches.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
